/* hw/rtl/sil_pkg.sv */
// shared types and constants for the silence region detector
`timescale 1ns / 1ps

package sil_pkg;

  // channel fields carried by one frame
  localparam int unsigned MaxChannels = 4;
  // widths fixed by the register map and result fields
  localparam int unsigned IdxW    = 3;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned CountW  = 32;
  localparam int unsigned ChanW   = 3;

  // configuration register indexes
  typedef enum logic [IdxW-1:0] {
    RegThreshold  = 3'd0,
    RegMinSilence = 3'd1,
    RegMinRegion  = 3'd2,
    RegPreRoll    = 3'd3,
    RegPostRoll   = 3'd4,
    RegStreamLen  = 3'd5,
    RegActiveChan = 3'd6
  } cfg_reg_e;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [ThreshW-1:0] threshold;
    logic [CountW-1:0]  min_silence;
    logic [CountW-1:0]  min_region;
    logic [CountW-1:0]  pre_roll;
    logic [CountW-1:0]  post_roll;
    logic [CountW-1:0]  len;      // stream length, zero taken as one
    logic [CountW-1:0]  len_m1;   // index of the final frame
    logic [ChanW-1:0]   active;
  } sil_cfg_t;

  // region found by the tracker, before length check and widening
  typedef struct packed {
    logic [CountW-1:0] first_idx;
    logic [CountW-1:0] last_idx;
  } sil_event_t;

endpackage

/* hw/rtl/sil_if.sv */
// valid/ready channel interfaces: audio frames, regions and configuration writes
`timescale 1ns / 1ps

interface sil_frame_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_ch0;
  logic signed [SAMPLE_BITS-1:0] sample_ch1;
  logic signed [SAMPLE_BITS-1:0] sample_ch2;
  logic signed [SAMPLE_BITS-1:0] sample_ch3;

  modport source (output valid, output sample_ch0, output sample_ch1,
                  output sample_ch2, output sample_ch3, input ready);
  modport sink (input valid, input sample_ch0, input sample_ch1,
                input sample_ch2, input sample_ch3, output ready);
endinterface

interface sil_region_if;
  logic        valid;
  logic        ready;
  logic [31:0] region_start;
  logic [31:0] region_end;

  modport source (output valid, output region_start, output region_end, input ready);
  modport sink (input valid, input region_start, input region_end, output ready);
endinterface

interface sil_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/sil_lane.sv */
// one channel lane: sample magnitude, zeroed when the channel is not examined
`timescale 1ns / 1ps

module sil_lane #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          active_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic        [SAMPLE_BITS-1:0] mag_o
);

  logic [SAMPLE_BITS-1:0] mag_d;
  logic [SAMPLE_BITS-1:0] mag_q;

  // absolute value; the most negative code maps to its unsigned magnitude
  always_comb begin
    if (!active_i) begin
      mag_d = '0;
    end else if (sample_i[SAMPLE_BITS-1]) begin
      mag_d = (~sample_i) + SAMPLE_BITS'(1);
    end else begin
      mag_d = sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
    end
  end

  assign mag_o = mag_q;

endmodule

/* hw/rtl/sil_merge.sv */
// merge stage: peak over the lanes and silence decision
`timescale 1ns / 1ps

module sil_merge #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [SAMPLE_BITS-1:0]            mag_i [sil_pkg::MaxChannels],
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [sil_pkg::ThreshW-1:0]       threshold_i,
  output logic                              silent_o,
  output logic                              valid_o,
  input  logic                              ready_i
);
  import sil_pkg::*;

  localparam int unsigned CmpW = (SAMPLE_BITS > ThreshW) ? SAMPLE_BITS : ThreshW;

  logic [SAMPLE_BITS-1:0] peak;
  logic                   silent_d;
  logic                   silent_q;
  logic                   valid_q;

  // largest magnitude over the lanes
  always_comb begin
    peak = '0;
    for (int i = 0; i < MaxChannels; i++) begin
      if (mag_i[i] > peak) begin
        peak = mag_i[i];
      end
    end
    silent_d = CmpW'(peak) < CmpW'(threshold_i);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      silent_q <= silent_d;
    end
  end

  assign silent_o = silent_q;
  assign valid_o  = valid_q;

endmodule

/* hw/rtl/sil_tracker.sv */
// region tracker: open, quiet count, close and end-of-scan handling
`timescale 1ns / 1ps

module sil_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sil_pkg::sil_cfg_t   cfg_i,
  input  logic                silent_i,
  input  logic                valid_i,
  output logic                ready_o,
  output sil_pkg::sil_event_t evt_o,
  output logic                evt_valid_o,
  input  logic                evt_ready_i
);
  import sil_pkg::*;

  logic              in_region_q, in_region_d;
  logic [CountW-1:0] open_start_q, open_start_d;
  logic [CountW-1:0] quiet_q, quiet_d;
  logic [CountW-1:0] frame_q, frame_d;
  logic [CountW-1:0] quiet_inc;
  logic              close;
  logic              last;
  logic              hit;
  logic              fire;
  sil_event_t        evt_d;
  sil_event_t        evt_q;
  logic              evt_valid_q;

  assign ready_o = !evt_valid_q || evt_ready_i;
  assign fire    = valid_i && ready_o;

  // next state for one frame
  always_comb begin
    in_region_d  = in_region_q;
    open_start_d = open_start_q;
    quiet_d      = quiet_q;
    close        = 1'b0;
    quiet_inc    = (quiet_q == '1) ? quiet_q : quiet_q + CountW'(1);
    last         = frame_q >= cfg_i.len_m1;

    if (!in_region_q) begin
      if (!silent_i) begin
        in_region_d  = 1'b1;
        open_start_d = frame_q;
        quiet_d      = '0;
      end
    end else if (silent_i) begin
      if (quiet_inc >= cfg_i.min_silence) begin
        close       = 1'b1;
        in_region_d = 1'b0;
        quiet_d     = '0;
      end else begin
        quiet_d = quiet_inc;
      end
    end else begin
      quiet_d = '0;
    end

    // region closed by silence, or still open at the final frame
    evt_d.first_idx = open_start_d;
    evt_d.last_idx  = close ? (frame_q - cfg_i.min_silence) : cfg_i.len;
    hit             = close || (last && in_region_d);

    if (last) begin
      in_region_d  = 1'b0;
      open_start_d = '0;
      quiet_d      = '0;
      frame_d      = '0;
    end else begin
      frame_d = frame_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_region_q  <= 1'b0;
      open_start_q <= '0;
      quiet_q      <= '0;
      frame_q      <= '0;
      evt_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        in_region_q  <= in_region_d;
        open_start_q <= open_start_d;
        quiet_q      <= quiet_d;
        frame_q      <= frame_d;
      end
      if (ready_o) begin
        evt_valid_q <= fire && hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      evt_q <= evt_d;
    end
  end

  assign evt_o       = evt_q;
  assign evt_valid_o = evt_valid_q;

endmodule

/* hw/rtl/sil_emit.sv */
// result stage: length check, pre/post-roll widening and output register
`timescale 1ns / 1ps

module sil_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sil_pkg::sil_cfg_t           cfg_i,
  input  sil_pkg::sil_event_t         evt_i,
  input  logic                        evt_valid_i,
  output logic                        evt_ready_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [sil_pkg::CountW-1:0]  start_o,
  output logic [sil_pkg::CountW-1:0]  end_o
);
  import sil_pkg::*;

  logic [CountW-1:0] length;
  logic              keep;
  logic [CountW-1:0] start_d;
  logic [CountW:0]   end_sum;
  logic [CountW-1:0] end_d;
  logic              valid_q;
  logic [CountW-1:0] start_q;
  logic [CountW-1:0] end_q;

  // length check and widening with clamps
  always_comb begin
    length  = (evt_i.last_idx > evt_i.first_idx) ? (evt_i.last_idx - evt_i.first_idx) : '0;
    keep    = length >= cfg_i.min_region;
    start_d = (evt_i.first_idx > cfg_i.pre_roll) ? (evt_i.first_idx - cfg_i.pre_roll) : '0;
    end_sum = {1'b0, evt_i.last_idx} + {1'b0, cfg_i.post_roll};
    end_d   = (end_sum > {1'b0, cfg_i.len}) ? cfg_i.len : end_sum[CountW-1:0];
  end

  assign evt_ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (evt_ready_o) begin
      valid_q <= evt_valid_i && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_ready_o && evt_valid_i) begin
      start_q <= start_d;
      end_q   <= end_d;
    end
  end

  assign valid_o = valid_q;
  assign start_o = start_q;
  assign end_o   = end_q;

endmodule

/* hw/rtl/silence_region_detector.sv */
// top level of the silence region detector
`timescale 1ns / 1ps

// Silence region detector. Takes one audio frame of four signed samples per
// transfer and reports loud regions as (region_start, region_end) frame
// indexes, widened by pre-roll and post-roll and clamped to [0, stream
// length]. One frame is accepted every clock cycle while the pipeline is not
// stalled. A result is formed through the magnitude lanes, peak merge, region
// tracker and result register, in that order. Each stage holds its item
// under output backpressure so the input stalls only when all stages are full.
// The per-frame tracker update is a loop through the tracker registers, which
// sets the rate of one frame per cycle. The user must write configuration through
// the cfg channel only while no frame is in flight; the block itself does not
// enforce this. Register indexes follow threshold, minimum silence, minimum
// region, pre-roll, post-roll, stream length, active channels.
module silence_region_detector #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sil_cfg_if.sink     cfg_i,
  sil_frame_if.sink   frame_i,
  sil_region_if.source region_o
);
  import sil_pkg::*;

  logic [ThreshW-1:0] threshold_q;
  logic [CountW-1:0]  min_silence_q;
  logic [CountW-1:0]  min_region_q;
  logic [CountW-1:0]  pre_roll_q;
  logic [CountW-1:0]  post_roll_q;
  logic [CountW-1:0]  stream_len_q;
  logic [ChanW-1:0]   active_q;
  sil_cfg_t           cfg;

  logic signed [SAMPLE_BITS-1:0] samples [MaxChannels];
  logic        [SAMPLE_BITS-1:0] mags    [MaxChannels];
  logic                          lane_valid_q;
  logic                          lane_ready;
  logic                          merge_ready;
  logic                          merge_valid;
  logic                          silent;
  logic                          track_ready;
  sil_event_t                    evt;
  logic                          evt_valid;
  logic                          evt_ready;

  // configuration register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= ThreshW'(1024);
      min_silence_q <= CountW'(4410);
      min_region_q  <= CountW'(4410);
      pre_roll_q    <= '0;
      post_roll_q   <= '0;
      stream_len_q  <= CountW'(1);
      active_q      <= ChanW'(2);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        RegThreshold:  threshold_q   <= cfg_i.data[ThreshW-1:0];
        RegMinSilence: min_silence_q <= cfg_i.data;
        RegMinRegion:  min_region_q  <= cfg_i.data;
        RegPreRoll:    pre_roll_q    <= cfg_i.data;
        RegPostRoll:   post_roll_q   <= cfg_i.data;
        RegStreamLen:  stream_len_q  <= cfg_i.data;
        RegActiveChan: active_q      <= cfg_i.data[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // derived configuration, zero stream length taken as one
  always_comb begin
    cfg.threshold   = threshold_q;
    cfg.min_silence = min_silence_q;
    cfg.min_region  = min_region_q;
    cfg.pre_roll    = pre_roll_q;
    cfg.post_roll   = post_roll_q;
    cfg.len         = (stream_len_q == '0) ? CountW'(1) : stream_len_q;
    cfg.len_m1      = (stream_len_q == '0) ? '0 : stream_len_q - CountW'(1);
    cfg.active      = active_q;
  end

  // magnitude lanes
  assign samples[0] = frame_i.sample_ch0;
  assign samples[1] = frame_i.sample_ch1;
  assign samples[2] = frame_i.sample_ch2;
  assign samples[3] = frame_i.sample_ch3;

  assign lane_ready    = !lane_valid_q || merge_ready;
  assign frame_i.ready = lane_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
    end else if (lane_ready) begin
      lane_valid_q <= frame_i.valid;
    end
  end

  for (genvar g = 0; g < MaxChannels; g++) begin : g_lane
    sil_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (lane_ready),
      .active_i(cfg.active > ChanW'(g)),
      .sample_i(samples[g]),
      .mag_o   (mags[g])
    );
  end

  // peak and silence decision
  sil_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mag_i      (mags),
    .valid_i    (lane_valid_q),
    .ready_o    (merge_ready),
    .threshold_i(cfg.threshold),
    .silent_o   (silent),
    .valid_o    (merge_valid),
    .ready_i    (track_ready)
  );

  // region tracking
  sil_tracker u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .silent_i   (silent),
    .valid_i    (merge_valid),
    .ready_o    (track_ready),
    .evt_o      (evt),
    .evt_valid_o(evt_valid),
    .evt_ready_i(evt_ready)
  );

  // result formation and output register
  sil_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .evt_i      (evt),
    .evt_valid_i(evt_valid),
    .evt_ready_o(evt_ready),
    .valid_o    (region_o.valid),
    .ready_i    (region_o.ready),
    .start_o    (region_o.region_start),
    .end_o      (region_o.region_end)
  );

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the silence region detector
`timescale 1ns / 1ps

module testbench;
  import sil_pkg::*;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned IdlePct = 32;
  // leave room for frames that cause nothing
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned LimitNs = 4_000_000;
  localparam logic [31:0] MaxWord = 32'hFFFF_FFFF;

  typedef logic [MaxChannels-1:0][SampleBits-1:0] frame_t;

  typedef struct packed {
    logic [CountW-1:0] start_idx;
    logic [CountW-1:0] end_idx;
  } region_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sil_cfg_if cfg_bus ();
  sil_frame_if #(.SAMPLE_BITS(SampleBits)) frame_bus ();
  sil_region_if region_bus ();

  silence_region_detector #(.SAMPLE_BITS(SampleBits)) uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_bus),
    .frame_i (frame_bus),
    .region_o(region_bus)
  );

  // register copy kept by the predictor
  longint unsigned thresh_q, min_silence_q, min_region_q;
  longint unsigned pre_roll_q, post_roll_q, stream_len_q, chans_q;
  // scan state kept by the predictor
  bit              in_region_q;
  longint unsigned open_start_q, quiet_q, frame_idx_q;

  region_t pending_regions[$];
  int      fail_count = 0;
  bit      tx_steady = 1'b0;
  bit      rx_steady = 1'b0;
  int      hold_len = 0;
  int      hold_reqs = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic bit long_enough(longint unsigned s, longint unsigned e);
    return ((e > s) ? e - s : 0) >= min_region_q;
  endfunction

  // widen by pre-roll and post-roll, clamp, and queue the region
  function automatic void push_region(longint unsigned s, longint unsigned e,
                                      longint unsigned len);
    region_t         r;
    longint unsigned lo, hi;
    lo = (s > pre_roll_q) ? s - pre_roll_q : 0;
    hi = e + post_roll_q;
    if (hi > len) hi = len;
    r.start_idx = 32'(lo);
    r.end_idx   = 32'(hi);
    pending_regions = {pending_regions, r};
  endfunction

  // advance the region tracker by one accepted frame
  function automatic void track_frame(frame_t f);
    longint unsigned len, peak, close_at;
    longint          v;
    int              n;
    bit              silent, last;
    len  = (stream_len_q == 0) ? 1 : stream_len_q;
    n    = (chans_q > MaxChannels) ? MaxChannels : int'(chans_q);
    peak = 0;
    for (int k = 0; k < n; k++) begin
      v = longint'($signed(f[k]));
      if (v < 0) v = -v;
      if (v > peak) peak = v;
    end
    silent = peak < thresh_q;
    last   = (frame_idx_q + 1) >= len;

    if (!in_region_q) begin
      if (!silent) begin
        in_region_q  = 1'b1;
        open_start_q = frame_idx_q;
        quiet_q      = 0;
      end
    end else if (silent) begin
      if (quiet_q < 64'hFFFF_FFFF) quiet_q++;
      if (quiet_q >= min_silence_q) begin
        close_at = frame_idx_q - min_silence_q;
        if (long_enough(open_start_q, close_at)) push_region(open_start_q, close_at, len);
        in_region_q = 1'b0;
        quiet_q     = 0;
      end
    end else begin
      quiet_q = 0;
    end

    // final frame of the scan closes an open region
    if (last) begin
      if (in_region_q && long_enough(open_start_q, len)) push_region(open_start_q, len, len);
      in_region_q  = 1'b0;
      open_start_q = 0;
      quiet_q      = 0;
      frame_idx_q  = 0;
    end else begin
      frame_idx_q++;
    end
  endfunction

  function automatic frame_t frame_of(int a, int b, int c, int d);
    frame_t f;
    f[0] = 16'(a);
    f[1] = 16'(b);
    f[2] = 16'(c);
    f[3] = 16'(d);
    return f;
  endfunction

  // loud or silent frame against the current threshold, idle channels random
  function automatic frame_t make_frame(bit loud);
    frame_t f;
    int     n, hot, mag, thr;
    thr = int'(thresh_q);
    n   = (chans_q > MaxChannels) ? MaxChannels : int'(chans_q);
    hot = (n > 0) ? $urandom_range(n - 1) : 0;
    for (int k = 0; k < MaxChannels; k++) begin
      if (k >= n || (loud && k != hot) || (!loud && thr == 0)) begin
        f[k] = 16'($urandom);
      end else begin
        if (loud) mag = $urandom_range(32768, thr);
        else mag = $urandom_range(thr - 1, 0);
        if (mag == 32768 || $urandom_range(1)) f[k] = 16'(-mag);
        else f[k] = 16'(mag);
      end
    end
    return f;
  endfunction

  // one frame transfer, with a random gap ahead of it unless the stream is steady
  task automatic send_frame(frame_t f);
    if (!tx_steady && $urandom_range(99) < IdlePct) begin
      frame_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IdlePct);
    end
    frame_bus.valid      <= 1'b1;
    frame_bus.sample_ch0 <= f[0];
    frame_bus.sample_ch1 <= f[1];
    frame_bus.sample_ch2 <= f[2];
    frame_bus.sample_ch3 <= f[3];
    do @(posedge clk); while (!frame_bus.ready);
    track_frame(f);
  endtask

  // loud bursts and silent runs, with some raw noise frames
  task automatic send_mixed(int count);
    int sent, runs;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        send_frame(frame_t'({$urandom, $urandom}));
        sent++;
      end else begin
        runs = $urandom_range(12, 1);
        repeat (runs) send_frame(make_frame(1'b1));
        sent += runs;
        runs = $urandom_range(14, 0);
        repeat (runs) send_frame(make_frame(1'b0));
        sent += runs;
      end
    end
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [31:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      RegThreshold:  thresh_q      = value[ThreshW-1:0];
      RegMinSilence: min_silence_q = value;
      RegMinRegion:  min_region_q  = value;
      RegPreRoll:    pre_roll_q    = value;
      RegPostRoll:   post_roll_q   = value;
      RegStreamLen:  stream_len_q  = value;
      RegActiveChan: chans_q       = value[ChanW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_all(logic [31:0] thr, logic [31:0] msil, logic [31:0] mreg,
                         logic [31:0] pre, logic [31:0] post, logic [31:0] len,
                         logic [31:0] chans);
    cfg_write(RegThreshold, thr);
    cfg_write(RegMinSilence, msil);
    cfg_write(RegMinRegion, mreg);
    cfg_write(RegPreRoll, pre);
    cfg_write(RegPostRoll, post);
    cfg_write(RegStreamLen, len);
    cfg_write(RegActiveChan, chans);
  endtask

  // stop frames, wait for every pending region, then let the pipeline empty
  task automatic settle();
    frame_bus.valid <= 1'b0;
    while (pending_regions.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // reset values give one-frame scans that are always too short
  task automatic test_reset_values();
    send_frame(frame_of(32767, -32768, 0, 0));
    send_frame(frame_of(0, 0, 0, 0));
  endtask

  // sample extremes around the threshold on all four channels
  task automatic test_sample_extremes();
    settle();
    cfg_all(1024, 2, 0, 1, 3, 8, 4);
    send_frame(frame_of(-32768, 0, 0, 0));
    send_frame(frame_of(1023, -1023, 0, -1));
    send_frame(frame_of(1, 0, 0, 0));
    send_frame(frame_of(0, 0, 0, 1024));
    send_frame(frame_of(0, -1024, 0, 0));
    send_frame(frame_of(32767, 0, 0, 0));
    send_frame(frame_of(0, 0, -1023, 0));
    send_frame(frame_of(0, 0, 0, 0));
  endtask

  // stream length of zero makes every frame the last one
  task automatic test_zero_stream_length();
    settle();
    cfg_all(1024, 2, 0, 0, 0, 0, 2);
    send_frame(frame_of(5000, 0, 0, 0));
    send_frame(frame_of(100, -100, 20000, -20000));
  endtask

  // channel counts above the channel fields examine all of them
  task automatic test_channel_count();
    settle();
    cfg_write(RegActiveChan, 7);
    send_frame(frame_of(0, 0, 0, -2000));
    settle();
    cfg_write(RegActiveChan, 5);
    send_frame(frame_of(0, 0, 0, 500));
  endtask

  // no active channel gives a peak of zero
  task automatic test_no_channels();
    settle();
    cfg_write(RegActiveChan, 0);
    cfg_write(RegThreshold, 0);
    send_frame(frame_of(32767, 0, 0, 0));
    settle();
    cfg_write(RegThreshold, 1);
    send_frame(frame_of(-32768, -32768, -32768, -32768));
  endtask

  // first silent frame closes the region when no silence is required
  task automatic test_zero_min_silence();
    settle();
    cfg_all(1024, 0, 0, 0, 0, 10, 1);
    send_frame(frame_of(2000, 0, 0, 0));
    send_frame(frame_of(0, 0, 0, 0));
    send_frame(frame_of(-3000, 0, 0, 0));
  endtask

  // stream length lowered below the current frame index mid-scan, with a region open
  task automatic test_lowered_scan();
    settle();
    cfg_all(1024, 1, 0, 0, 100, 100, 1);
    send_frame(frame_of(0, 0, 0, 0));
    send_frame(frame_of(5, 0, 0, 0));
    send_frame(frame_of(4000, 0, 0, 0));
    send_frame(frame_of(-4000, 0, 0, 0));
    settle();
    cfg_write(RegStreamLen, 3);
    send_frame(frame_of(9000, 0, 0, 0));
  endtask

  // roll sums beyond 32 bits before the clamp
  task automatic test_wide_sums();
    settle();
    cfg_all(1024, 1, 0, MaxWord, MaxWord, MaxWord, 1);
    send_frame(frame_of(1500, 0, 0, 0));
    send_frame(frame_of(-1500, 0, 0, 0));
    send_frame(frame_of(0, 0, 0, 0));
  endtask

  // region sink held off while frames keep coming, then a full drain
  task automatic test_backpressure();
    settle();
    cfg_all(1024, 0, 0, 0, 0, 1, 4);
    tx_steady = 1'b1;
    hold_len  <= 300;
    hold_reqs <= hold_reqs + 1;
    repeat (60) send_frame(make_frame(1'b1));
    tx_steady = 1'b0;
    settle();
    send_mixed(40);
  endtask

  // back-to-back transfers on both sides
  task automatic test_steady_stream();
    settle();
    cfg_all(2000, 3, 4, 5, 5, 40, 3);
    tx_steady = 1'b1;
    rx_steady <= 1'b1;
    send_mixed(150);
    tx_steady = 1'b0;
    rx_steady <= 1'b0;
  endtask

  // random settings per phase, register extremes in the early phases
  task automatic test_random_scans();
    logic [31:0] thr, msil, mreg, pre, post, len, chans;
    for (int phase = 0; phase < 10; phase++) begin
      thr   = $urandom_range(20000, 64);
      msil  = $urandom_range(8, 0);
      mreg  = $urandom_range(10, 0);
      pre   = $urandom_range(20, 0);
      post  = $urandom_range(20, 0);
      len   = $urandom_range(64, 1);
      chans = $urandom_range(4, 1);
      case (phase)
        0: thr = 32768;
        1: thr = 0;
        2: msil = MaxWord;
        3: mreg = MaxWord;
        4: len = 0;
        5: chans = 7;
        6: begin
          pre  = MaxWord;
          post = MaxWord;
        end
        7: chans = 0;
        default: ;
      endcase
      settle();
      cfg_all(thr, msil, mreg, pre, post, len, chans);
      send_mixed(100);
    end
  endtask

  // region sink: random stalls, requested hold-offs, and result checking
  initial begin
    region_t want;
    int      hold_left, seen_reqs;
    hold_left = 0;
    seen_reqs = 0;
    region_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && region_bus.valid && region_bus.ready) begin
        if (pending_regions.size() == 0) begin
          note_fail($sformatf("unexpected region start %0d end %0d",
                              region_bus.region_start, region_bus.region_end));
        end else begin
          want = pending_regions.pop_front();
          if (region_bus.region_start !== want.start_idx)
            note_fail($sformatf("region_start expected %0d got %0d",
                                want.start_idx, region_bus.region_start));
          if (region_bus.region_end !== want.end_idx)
            note_fail($sformatf("region_end expected %0d got %0d",
                                want.end_idx, region_bus.region_end));
        end
      end
      if (hold_reqs != seen_reqs) begin
        seen_reqs = hold_reqs;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        region_bus.ready <= 1'b0;
      end else if (rx_steady) begin
        region_bus.ready <= 1'b1;
      end else begin
        region_bus.ready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // run limit
  initial begin
    #(LimitNs);
    $display("TB_ERROR");
    $finish;
  end

  // test sequence
  initial begin
    frame_bus.valid      <= 1'b0;
    frame_bus.sample_ch0 <= '0;
    frame_bus.sample_ch1 <= '0;
    frame_bus.sample_ch2 <= '0;
    frame_bus.sample_ch3 <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= RegThreshold;
    cfg_bus.data         <= '0;
    thresh_q      = 1024;
    min_silence_q = 4410;
    min_region_q  = 4410;
    pre_roll_q    = 0;
    post_roll_q   = 0;
    stream_len_q  = 1;
    chans_q       = 2;
    in_region_q   = 1'b0;
    open_start_q  = 0;
    quiet_q       = 0;
    frame_idx_q   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_sample_extremes();
    test_zero_stream_length();
    test_channel_count();
    test_no_channels();
    test_zero_min_silence();
    test_lowered_scan();
    test_wide_sums();
    test_backpressure();
    test_steady_stream();
    test_random_scans();

    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sil_pkg.sv
hw/rtl/sil_if.sv
hw/rtl/sil_lane.sv
hw/rtl/sil_merge.sv
hw/rtl/sil_tracker.sv
hw/rtl/sil_emit.sv
hw/rtl/silence_region_detector.sv
tb/sv/testbench.sv
